@@ rtl/core/pdtf_pkg.sv @@
// ----------------------------------------------------------------------------
// pdtf_pkg
// Shared types and token codes for the PD transmit FIFO token framer.
// ----------------------------------------------------------------------------
package pdtf_pkg;

  // PHY FIFO token codes
  localparam logic [7:0] TOK_SOP1    = 8'h12;
  localparam logic [7:0] TOK_SOP2    = 8'h13;
  localparam logic [7:0] TOK_PACKSYM = 8'h80;
  localparam logic [7:0] TOK_JAMCRC  = 8'hFF;
  localparam logic [7:0] TOK_EOP     = 8'h14;
  localparam logic [7:0] TOK_TXOFF   = 8'hFE;
  localparam logic [7:0] TOK_TXON    = 8'hA1;

  // Input item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Last step index of each output segment
  localparam logic [2:0] HDR_LAST_STEP = 3'd6;
  localparam logic [2:0] SEG4_LAST_STEP = 3'd3;

  typedef enum logic {
    CMD_HDR,
    CMD_DATA
  } cmd_op_t;

  // One classified item handed from front to back
  typedef struct packed {
    cmd_op_t     op;
    logic        trailer;   // append JAM_CRC/EOP/TXOFF/TXON after this item
    logic [31:0] word;
  } cmd_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DATA,
    BK_TRL
  } back_state_t;

endpackage

@@ rtl/core/pdtf_front.sv @@
// ----------------------------------------------------------------------------
// pdtf_front
// Accepts input items, tracks the open frame and queues byte commands.
// ----------------------------------------------------------------------------
module pdtf_front
  import pdtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] word
  input  logic        in_tuser,   // [0] kind
  input  q_status_t   q_status,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [2:0] objects_left_r, objects_left_nxt;
  logic       frame_open_r, frame_open_nxt;
  logic       accept;
  logic [2:0] hdr_count;
  logic [2:0] left_dec;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign hdr_count = in_tdata[14:12];
  assign left_dec  = objects_left_r - 3'd1;

  // Classify the item and update the frame state
  always_comb begin
    objects_left_nxt = objects_left_r;
    frame_open_nxt   = frame_open_r;
    push             = 1'b0;
    push_cmd.op      = CMD_HDR;
    push_cmd.trailer = 1'b0;
    push_cmd.word    = in_tdata;
    if (accept) begin
      if (in_tuser == KIND_HEADER) begin
        push             = 1'b1;
        push_cmd.op      = CMD_HDR;
        push_cmd.trailer = (hdr_count == 3'd0);
        objects_left_nxt = hdr_count;
        frame_open_nxt   = (hdr_count != 3'd0);
      end else if (frame_open_r) begin
        push             = 1'b1;
        push_cmd.op      = CMD_DATA;
        push_cmd.trailer = (left_dec == 3'd0);
        objects_left_nxt = left_dec;
        frame_open_nxt   = (left_dec != 3'd0);
      end
      // data with no frame open: drop
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      objects_left_r <= 3'd0;
      frame_open_r   <= 1'b0;
    end else begin
      objects_left_r <= objects_left_nxt;
      frame_open_r   <= frame_open_nxt;
    end
  end

endmodule

@@ rtl/core/pdtf_queue.sv @@
// ----------------------------------------------------------------------------
// pdtf_queue
// Short command FIFO that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
module pdtf_queue
  import pdtf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = mem_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/pdtf_back.sv @@
// ----------------------------------------------------------------------------
// pdtf_back
// Byte sequencer: expands queued commands into tokens, one byte per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module pdtf_back
  import pdtf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // frame_end
);

  back_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        advance;
  logic        seg_end;
  logic [7:0]  byte_sel;
  logic        last_sel;

  assign advance = (state_r != BK_IDLE) && (!out_valid_r || out_tready);

  always_comb begin
    unique case (state_r)
      BK_HDR:  seg_end = (step_r == HDR_LAST_STEP);
      BK_DATA: seg_end = (step_r == SEG4_LAST_STEP);
      BK_TRL:  seg_end = (step_r == SEG4_LAST_STEP);
      default: seg_end = 1'b0;
    endcase
  end

  // Next state: step through segments, chain the next command without a gap
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    pop       = 1'b0;
    if (state_r == BK_IDLE) begin
      if (!q_status.empty) begin
        pop       = 1'b1;
        cmd_nxt   = head;
        state_nxt = (head.op == CMD_HDR) ? BK_HDR : BK_DATA;
        step_nxt  = 3'd0;
      end
    end else if (advance) begin
      if (!seg_end) begin
        step_nxt = step_r + 3'd1;
      end else if (state_r != BK_TRL && cmd_r.trailer) begin
        state_nxt = BK_TRL;
        step_nxt  = 3'd0;
      end else if (!q_status.empty) begin
        pop       = 1'b1;
        cmd_nxt   = head;
        state_nxt = (head.op == CMD_HDR) ? BK_HDR : BK_DATA;
        step_nxt  = 3'd0;
      end else begin
        state_nxt = BK_IDLE;
        step_nxt  = 3'd0;
      end
    end
  end

  // Output: select the byte for the current step
  always_comb begin
    byte_sel = 8'h00;
    last_sel = 1'b0;
    unique case (state_r)
      BK_HDR: begin
        case (step_r)
          3'd0, 3'd1, 3'd2: byte_sel = TOK_SOP1;
          3'd3:             byte_sel = TOK_SOP2;
          3'd4:             byte_sel = TOK_PACKSYM | {3'b000, cmd_r.word[14:12], 2'b10};
          3'd5:             byte_sel = cmd_r.word[7:0];
          default:          byte_sel = cmd_r.word[15:8];
        endcase
      end
      BK_DATA: begin
        case (step_r[1:0])
          2'd0:    byte_sel = cmd_r.word[7:0];
          2'd1:    byte_sel = cmd_r.word[15:8];
          2'd2:    byte_sel = cmd_r.word[23:16];
          default: byte_sel = cmd_r.word[31:24];
        endcase
      end
      BK_TRL: begin
        case (step_r[1:0])
          2'd0:    byte_sel = TOK_JAMCRC;
          2'd1:    byte_sel = TOK_EOP;
          2'd2:    byte_sel = TOK_TXOFF;
          default: begin
            byte_sel = TOK_TXON;
            last_sel = 1'b1;
          end
        endcase
      end
      default: begin
        byte_sel = 8'h00;
        last_sel = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // Output register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/pd_tx_fifo_token_framer_top.sv @@
// ----------------------------------------------------------------------------
// pd_tx_fifo_token_framer_top
// Frames PD messages into the transmit token byte stream of a PHY FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser is the item kind (0 header, 1 data object),
//   in_tdata the 32-bit word. A header item yields SOP1 x3, SOP2, the
//   packed-symbol count token and two header bytes; each data item yields
//   four bytes, low byte first. The trailer JAM_CRC, EOP, TXOFF, TXON
//   follows the last object (or the header when it has no objects), and
//   out_tlast marks TXON. Data with no frame open is dropped.
//   Output stream: one byte per out_tdata item.
// On an idle block the first byte of an item passes through the queue,
//   the sequencer load and the output register before it is presented.
// Throughput: the back sequencer emits one byte per cycle while the
//   receiver takes them. The front accepts one item per cycle while the
//   command queue has room.
// Reset clears the frame state, the queue and the output register.
// When the receiver stalls, the output byte holds, the sequencer waits and
//   the queue fills; in_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module pd_tx_fifo_token_framer_top
  import pdtf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] word
  input  logic        in_tuser,    // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // frame_end
);

  q_status_t q_status;
  logic      push, pop;
  cmd_t      push_cmd, head;

  pdtf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pdtf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  pdtf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

@@ rtl/core/pdtf_checker.sv @@
// ----------------------------------------------------------------------------
// pdtf_checker
// Port-level checks for the PD transmit token framer, bound to the top.
// ----------------------------------------------------------------------------
module pdtf_checker
  import pdtf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // Frame end only on the TXON token
  a_last_txon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == TOK_TXON)
    else $error("frame end on a byte other than TXON");

  // Reset empties the output and the queue
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

endmodule

bind pd_tx_fifo_token_framer_top pdtf_checker u_pdtf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

@@ dv/pd_tx_fifo_token_framer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pd_tx_fifo_token_framer testbench
// Drives PD header and data object items into the framer and checks every
// token byte it emits against a predicted FIFO token stream. The stream
// covers well-formed frames of every object count, abandoned frames and
// stray data objects. Random idle cycles are inserted on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import pdtf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 520;

  typedef struct {
    logic [7:0] tok;
    logic       frame_end;
  } fifo_token_t;

  // Track the open frame and hold the token bytes still owed by the block
  class frame_token_tracker;
    fifo_token_t owed_tokens[$];
    logic [2:0]  objects_left;
    logic        frame_open;
    int          errors;

    function new();
      objects_left = '0;
      frame_open   = 1'b0;
      errors       = 0;
    endfunction

    function void push_token(input logic [7:0] tok, input logic frame_end);
      fifo_token_t t;
      t.tok       = tok;
      t.frame_end = frame_end;
      owed_tokens.push_back(t);
    endfunction

    function void push_trailer();
      push_token(TOK_JAMCRC, 1'b0);
      push_token(TOK_EOP, 1'b0);
      push_token(TOK_TXOFF, 1'b0);
      push_token(TOK_TXON, 1'b1);
    endfunction

    // Note an accepted item; return how many token bytes it adds
    function int note_item(input logic kind, input logic [31:0] word);
      logic [2:0] count;
      int         start_size;
      start_size = owed_tokens.size();
      if (kind == KIND_HEADER) begin
        count = word[14:12];
        push_token(TOK_SOP1, 1'b0);
        push_token(TOK_SOP1, 1'b0);
        push_token(TOK_SOP1, 1'b0);
        push_token(TOK_SOP2, 1'b0);
        push_token(TOK_PACKSYM | {3'b000, count, 2'b10}, 1'b0);
        push_token(word[7:0], 1'b0);
        push_token(word[15:8], 1'b0);
        if (count == 3'd0) begin
          push_trailer();
          frame_open = 1'b0;
        end else begin
          frame_open = 1'b1;
        end
        objects_left = count;
      end else if (frame_open) begin
        push_token(word[7:0], 1'b0);
        push_token(word[15:8], 1'b0);
        push_token(word[23:16], 1'b0);
        push_token(word[31:24], 1'b0);
        objects_left = objects_left - 3'd1;
        if (objects_left == 3'd0) begin
          push_trailer();
          frame_open = 1'b0;
        end
      end
      return owed_tokens.size() - start_size;
    endfunction

    // Compare one emitted byte with the oldest owed token
    function void check_token(input logic [7:0] tok, input logic frame_end);
      fifo_token_t t;
      if (owed_tokens.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h last %b",
                 $time, tok, frame_end);
        errors++;
      end else begin
        t = owed_tokens.pop_front();
        if (tok !== t.tok) begin
          $display("%0t: out_tdata expected %02h actual %02h", $time, t.tok, tok);
          errors++;
        end
        if (frame_end !== t.frame_end) begin
          $display("%0t: out_tlast expected %b actual %b", $time, t.frame_end,
                   frame_end);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // [31:0] word
  logic        in_tuser   = 1'b0;  // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] out_byte
  logic        out_tlast;          // frame_end

  frame_token_tracker tracker = new();
  int  framed_items = 0;
  int  stall_cycles = 0;
  bit  quiet        = 1'b0;

  pd_tx_fifo_token_framer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // Predict on accepted items, check accepted bytes
  always @(posedge clk) begin
    int added;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        added = tracker.note_item(in_tuser, in_tdata);
        if (added > 0) framed_items++;
      end
      if (out_tvalid && out_tready) tracker.check_token(out_tdata, out_tlast);
    end
  end

  // Stall the byte sink at random
  always @(posedge clk) begin
    if (!quiet && $urandom_range(99) < 36) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item after random idle cycles and hold it until accepted
  task automatic send_item(input logic kind, input logic [31:0] word);
    while (!quiet && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every owed byte has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_tokens.size() != 0) @(posedge clk);
  endtask

  // Header with the given object count, then some of its data objects
  task automatic send_frame(input logic [2:0] count, input int n_data);
    logic [31:0] hdr;
    hdr        = $urandom;
    hdr[14:12] = count;
    send_item(KIND_HEADER, hdr);
    for (int i = 0; i < n_data; i++) send_item(KIND_DATA, $urandom);
  endtask

  initial begin
    int          roll;
    logic [2:0]  count;
    bit          mid_drained;
    mid_drained = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero-object headers, upper header bits set, stray data
    send_item(KIND_HEADER, 32'h0000_0000);
    send_item(KIND_HEADER, 32'hFFFF_8FFF);
    send_item(KIND_DATA,   32'hFFFF_FFFF);
    // Full seven-object frame with extreme words
    send_item(KIND_HEADER, 32'hFFFF_7FFF);
    send_item(KIND_DATA,   32'h0000_0000);
    send_item(KIND_DATA,   32'hFFFF_FFFF);
    send_item(KIND_DATA,   32'h1234_5678);
    send_item(KIND_DATA,   32'h8000_0001);
    send_item(KIND_DATA,   32'h7FFF_FFFE);
    send_item(KIND_DATA,   32'hA5A5_5A5A);
    send_item(KIND_DATA,   32'hDEAD_BEEF);
    // Single-object frame
    send_item(KIND_HEADER, 32'h0000_1000);
    send_item(KIND_DATA,   32'h5A5A_A5A5);
    // Header abandons an open frame
    send_item(KIND_HEADER, 32'h0000_3ABC);
    send_item(KIND_DATA,   32'h0F0F_F0F0);
    send_item(KIND_HEADER, 32'h0001_2000);
    send_item(KIND_DATA,   32'hF0F0_0F0F);
    send_item(KIND_DATA,   32'h0102_0304);
    // Stray data after a closed frame
    send_item(KIND_DATA,   32'h5555_AAAA);
    wait_drained();

    // Random: mostly complete frames, some cut short, some stray data
    while (framed_items < ITEM_TARGET) begin
      quiet = (framed_items >= 300 && framed_items < 400);
      if (!mid_drained && framed_items >= 200) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      roll  = $urandom_range(99);
      count = 3'($urandom_range(7));
      if (roll < 78) begin
        send_frame(count, count);
      end else if (roll < 90) begin
        send_frame(count, (count == 3'd0) ? 0 : $urandom_range(count - 1));
      end else begin
        repeat ($urandom_range(1, 2)) send_item(KIND_DATA, $urandom);
      end
    end
    quiet = 1'b0;

    // Wait for the last bytes and a few more cycles
    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.owed_tokens.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time,
               tracker.owed_tokens.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ pd_tx_fifo_token_framer_top.f @@
rtl/core/pdtf_pkg.sv
rtl/core/pdtf_front.sv
rtl/core/pdtf_queue.sv
rtl/core/pdtf_back.sv
rtl/core/pd_tx_fifo_token_framer_top.sv
rtl/core/pdtf_checker.sv
dv/pd_tx_fifo_token_framer_tb.sv
